FILE: rtl/core/phd_pkg.sv
`timescale 1ns / 1ps

package phd_pkg;

    // Result kinds; the error codes held by the decoder use the same values.
    localparam logic [1:0] KIND_BYTE         = 2'd0;
    localparam logic [1:0] KIND_OK           = 2'd1;
    localparam logic [1:0] KIND_NOT_PREFIXED = 2'd2;
    localparam logic [1:0] KIND_BAD_HEX      = 2'd3;
    localparam logic [1:0] ERR_NONE          = 2'd0;

    // Characters of interest
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_I_UP  = 8'h49;
    localparam logic [7:0] CH_I_LO  = 8'h69;
    localparam logic [7:0] CH_O_UP  = 8'h4F;
    localparam logic [7:0] CH_O_LO  = 8'h6F;
    localparam logic [7:0] CH_R_UP  = 8'h52;
    localparam logic [7:0] CH_R_LO  = 8'h72;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_A_UP  = 8'h41;
    localparam logic [7:0] CH_F_UP  = 8'h46;
    localparam logic [7:0] CH_A_LO  = 8'h61;
    localparam logic [7:0] CH_F_LO  = 8'h66;

    typedef struct packed {
        logic [1:0] result_kind;
        logic [7:0] decoded_byte;
        logic       final_result;
    } result_t;

    // What one accepted character pushes toward the output: a byte, a status, or both.
    typedef struct packed {
        logic    byte_vld;
        result_t byte_res;
        logic    stat_vld;
        result_t stat_res;
    } push_t;

    typedef struct packed {
        logic       is_ws;
        logic       is_hex;
        logic [3:0] nibble;
    } cls_t;

    function automatic cls_t classify(input logic [7:0] c);
        cls_t r;
        r.is_ws  = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF);
        r.is_hex = 1'b0;
        r.nibble = 4'h0;
        if (c >= CH_0 && c <= CH_9)
        begin
            r.is_hex = 1'b1;
            r.nibble = c[3:0];
        end
        else if ((c >= CH_A_UP && c <= CH_F_UP) || (c >= CH_A_LO && c <= CH_F_LO))
        begin
            r.is_hex = 1'b1;
            r.nibble = 4'(c[3:0] + 4'd9);
        end
        return r;
    endfunction

endpackage

FILE: rtl/core/phd_char_if.sv
`timescale 1ns / 1ps

interface phd_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_char;
    logic       end_of_text;

    modport source (output valid, output text_char, output end_of_text, input ready);
    modport sink   (input valid, input text_char, input end_of_text, output ready);
endinterface

FILE: rtl/core/phd_result_if.sv
`timescale 1ns / 1ps

interface phd_result_if;
    logic       valid;
    logic       ready;
    logic [1:0] result_kind;
    logic [7:0] decoded_byte;
    logic       final_result;

    modport source (output valid, output result_kind, output decoded_byte,
                    output final_result, input ready);
    modport sink   (input valid, input result_kind, input decoded_byte,
                    input final_result, output ready);
endinterface

FILE: rtl/core/prefixed_hex_text_decoder_top.sv
`timescale 1ns / 1ps

// Prefixed hex text decoder. Text arrives one character per word on chars,
// with end_of_text set on the last character. Leading space/tab/CR/LF are
// skipped, then a case-insensitive "IOR:" prefix is required; after that hex
// digit pairs (either case, whitespace allowed anywhere, even mid-pair) are
// emitted as byte words (result_kind 0) as soon as the second digit lands.
// The last character always produces a status word with final_result set:
// 1 ok, 2 not prefixed (includes short texts), 3 bad hex (bad character or
// odd digit count). After an error no more bytes come out; the consumer
// should drop the bytes of a text whose status is an error. After its
// status word the block starts over on the next character. Throughput is
// one character per clock while the output buffer can take it: the decoder
// state updates in the cycle a character is taken, and results go into a
// two-word output buffer. A character that yields both a byte and the
// status fills both words, so chars.ready stays low until the byte word is
// taken; with results.ready held high, all other characters are taken back
// to back. A character's first result word shows in the cycle after it.

module prefixed_hex_text_decoder_top
    import phd_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    phd_char_if.sink      chars,
    phd_result_if.source  results
);

    logic  in_ready;
    logic  accept;
    push_t push;

    assign chars.ready = in_ready;
    assign accept      = chars.valid && in_ready;

    // character classification, prefix tracking and nibble pairing
    phd_decode u_decode (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .text_char   (chars.text_char),
        .end_of_text (chars.end_of_text),
        .push        (push)
    );

    // result register: holds up to a byte word plus a status word
    phd_outbuf u_outbuf (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .push     (push),
        .in_ready (in_ready),
        .results  (results)
    );

endmodule

FILE: rtl/core/phd_decode.sv
`timescale 1ns / 1ps

module phd_decode
    import phd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  logic [7:0] text_char,
    input  logic       end_of_text,
    output push_t      push
);

    localparam logic [2:0] PH_LEAD  = 3'd0;
    localparam logic [2:0] PH_GOT_I = 3'd1;
    localparam logic [2:0] PH_GOT_O = 3'd2;
    localparam logic [2:0] PH_GOT_R = 3'd3;
    localparam logic [2:0] PH_BODY  = 3'd4;
    localparam logic [2:0] PH_ERROR = 3'd5;

    logic [2:0] phase_reg, phase_next;
    logic [3:0] high_nibble_reg, high_nibble_next;
    logic       have_high_reg, have_high_next;
    logic [1:0] error_code_reg, error_code_next;

    logic [2:0] ph;
    logic [3:0] hi;
    logic       have;
    logic [1:0] err;
    logic       byte_vld;
    logic [7:0] byte_val;
    logic [1:0] stat_kind;
    cls_t       cls;

    always_comb
    begin
        cls      = classify(text_char);
        ph       = phase_reg;
        hi       = high_nibble_reg;
        have     = have_high_reg;
        err      = error_code_reg;
        byte_vld = 1'b0;
        byte_val = 8'h00;

        unique case (phase_reg)
            PH_LEAD:
            begin
                if (!cls.is_ws)
                begin
                    if (text_char == CH_I_UP || text_char == CH_I_LO)
                        ph = PH_GOT_I;
                    else
                    begin
                        ph  = PH_ERROR;
                        err = KIND_NOT_PREFIXED;
                    end
                end
            end
            PH_GOT_I:
            begin
                if (text_char == CH_O_UP || text_char == CH_O_LO)
                    ph = PH_GOT_O;
                else
                begin
                    ph  = PH_ERROR;
                    err = KIND_NOT_PREFIXED;
                end
            end
            PH_GOT_O:
            begin
                if (text_char == CH_R_UP || text_char == CH_R_LO)
                    ph = PH_GOT_R;
                else
                begin
                    ph  = PH_ERROR;
                    err = KIND_NOT_PREFIXED;
                end
            end
            PH_GOT_R:
            begin
                if (text_char == CH_COLON)
                    ph = PH_BODY;
                else
                begin
                    ph  = PH_ERROR;
                    err = KIND_NOT_PREFIXED;
                end
            end
            PH_BODY:
            begin
                if (cls.is_ws)
                    ph = PH_BODY;
                else if (!cls.is_hex)
                begin
                    ph   = PH_ERROR;
                    err  = KIND_BAD_HEX;
                    have = 1'b0;
                    hi   = 4'h0;
                end
                else if (have_high_reg)
                begin
                    byte_vld = 1'b1;
                    byte_val = {high_nibble_reg, cls.nibble};
                    have     = 1'b0;
                    hi       = 4'h0;
                end
                else
                begin
                    have = 1'b1;
                    hi   = cls.nibble;
                end
            end
            default:
            begin
                // error phase and unused codes: swallow the rest of the text
                ph = phase_reg;
            end
        endcase

        // closing status, judged on the state after this character
        if (ph >= PH_ERROR)
            stat_kind = (err == ERR_NONE) ? KIND_BAD_HEX : err;
        else if (ph < PH_BODY)
            stat_kind = KIND_NOT_PREFIXED;
        else if (have)
            stat_kind = KIND_BAD_HEX;
        else
            stat_kind = KIND_OK;

        push.byte_vld              = byte_vld;
        push.byte_res.result_kind  = KIND_BYTE;
        push.byte_res.decoded_byte = byte_val;
        push.byte_res.final_result = 1'b0;
        push.stat_vld              = end_of_text;
        push.stat_res.result_kind  = stat_kind;
        push.stat_res.decoded_byte = 8'h00;
        push.stat_res.final_result = 1'b1;

        phase_next       = phase_reg;
        high_nibble_next = high_nibble_reg;
        have_high_next   = have_high_reg;
        error_code_next  = error_code_reg;
        if (accept)
        begin
            if (end_of_text)
            begin
                phase_next       = PH_LEAD;
                high_nibble_next = 4'h0;
                have_high_next   = 1'b0;
                error_code_next  = ERR_NONE;
            end
            else
            begin
                phase_next       = ph;
                high_nibble_next = hi;
                have_high_next   = have;
                error_code_next  = err;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_LEAD;
            high_nibble_reg <= 4'h0;
            have_high_reg   <= 1'b0;
            error_code_reg  <= ERR_NONE;
        end
        else
        begin
            phase_reg       <= phase_next;
            high_nibble_reg <= high_nibble_next;
            have_high_reg   <= have_high_next;
            error_code_reg  <= error_code_next;
        end
    end

    // a closed text leaves the decoder ready for a fresh one
    a_restart: assert property (@(posedge clk) disable iff (!rst_n)
        accept && end_of_text |=> phase_reg == PH_LEAD && !have_high_reg
                                  && error_code_reg == ERR_NONE)
        else $error("decoder state not cleared after end of text");

    // a pending nibble exists only inside the hex body
    a_nibble_in_body: assert property (@(posedge clk) disable iff (!rst_n)
        have_high_reg |-> phase_reg == PH_BODY)
        else $error("pending nibble outside hex body");

endmodule

FILE: rtl/core/phd_outbuf.sv
`timescale 1ns / 1ps

module phd_outbuf
    import phd_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  push_t               push,
    output logic                in_ready,
    phd_result_if.source        results
);

    result_t    slot0_reg, slot0_next;
    result_t    slot1_reg, slot1_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       pop;

    assign pop      = (cnt_reg != 2'd0) && results.ready;
    // take a word only when the buffer will be empty after this edge
    assign in_ready = (cnt_reg == 2'd0) || ((cnt_reg == 2'd1) && results.ready);

    always_comb
    begin
        slot0_next = slot0_reg;
        slot1_next = slot1_reg;
        cnt_next   = cnt_reg;
        if (accept)
        begin
            cnt_next   = 2'({1'b0, push.byte_vld} + {1'b0, push.stat_vld});
            slot0_next = push.byte_vld ? push.byte_res : push.stat_res;
            slot1_next = push.stat_res;
        end
        else if (pop)
        begin
            cnt_next   = 2'(cnt_reg - 2'd1);
            slot0_next = slot1_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= 2'd0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
    end

    assign results.valid        = (cnt_reg != 2'd0);
    assign results.result_kind  = slot0_reg.result_kind;
    assign results.decoded_byte = slot0_reg.decoded_byte;
    assign results.final_result = slot0_reg.final_result;

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg != 2'd3)
        else $error("result buffer overfilled");

    // two queued words are always a byte followed by its closing status
    a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg == 2'd2 |-> slot1_reg.final_result && !slot0_reg.final_result
                            && slot0_reg.result_kind == KIND_BYTE)
        else $error("queued pair out of order");

    a_byte_not_final: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid && results.result_kind == KIND_BYTE |-> !results.final_result)
        else $error("byte word flagged as final");

endmodule
